/* rtl/core/assert_macros.svh */
// Assertion macros shared by the character LCD controller modules.
// Each macro expects clk_i, and CLCD4_ASSERT also rst_ni, to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge once reset has been released.
`define CLCD4_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("clcd4 assertion failed");

// Check a property on every clock edge, reset included.
`define CLCD4_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("clcd4 assertion failed");

`endif

/* rtl/core/clcd4_pkg.sv */
// Shared types, constants and timing functions for the 4-bit character LCD controller.
// No dependencies; the front end, queue, sequencer and top level refer to it by scoped names.
package clcd4_pkg;

  localparam int unsigned WAIT_W      = 15;
  localparam int unsigned STEP_W      = 4;
  localparam int unsigned COL_W       = 6;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned INIT_XFERS  = 12;

  localparam logic [COL_W-1:0] LINE_LENGTH_RST = 6'd16;

  // Display timing in microseconds
  localparam logic [WAIT_W-1:0] RS_SETUP_US     = 15'd10;
  localparam logic [WAIT_W-1:0] NIB_POST_US     = 15'd50;
  localparam logic [WAIT_W-1:0] DATA_SETTLE_US  = 15'd50;
  localparam logic [WAIT_W-1:0] CMD_SETTLE_US   = 15'd2000;
  localparam logic [WAIT_W-1:0] CURSOR_EXTRA_US = 15'd50;
  localparam logic [WAIT_W-1:0] CLEAR_EXTRA_US  = 15'd2000;
  localparam logic [WAIT_W-1:0] POWER_UP_US     = 15'd20000;
  localparam logic [WAIT_W-1:0] WAKE_FIRST_US   = 15'd5050;
  localparam logic [WAIT_W-1:0] WAKE_NEXT_US    = 15'd1050;

  // Display command bytes
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_DDRAM     = 8'h80;
  localparam logic [7:0] ROW1_OFFSET   = 8'h40;
  localparam logic [3:0] NIB_WAKE      = 4'h3;
  localparam logic [3:0] NIB_4BIT      = 4'h2;

  typedef enum logic [2:0] {
    FUNC_INIT   = 3'd0,
    FUNC_CMD    = 3'd1,
    FUNC_DATA   = 3'd2,
    FUNC_CHAR   = 3'd3,
    FUNC_CURSOR = 3'd4,
    FUNC_CLEAR  = 3'd5,
    FUNC_HOME   = 3'd6,
    FUNC_GLYPH  = 3'd7
  } func_e;

  // Extra settling appended after the low nibble of a byte
  typedef enum logic [1:0] {
    EXTRA_NONE   = 2'd0,
    EXTRA_CURSOR = 2'd1,
    EXTRA_CLEAR  = 2'd2
  } extra_e;

  // One queued job: either the init run or one or two bytes
  typedef struct packed {
    logic       is_init;
    logic       has_pre;
    logic [7:0] pre_byte;
    logic       rs;
    logic [7:0] main_byte;
    extra_e     extra;
  } job_t;

  typedef struct packed {
    logic              reg_select;
    logic [3:0]        nibble;
    logic [WAIT_W-1:0] pre_wait_us;
    logic [WAIT_W-1:0] post_wait_us;
    logic              last;
  } xfer_t;

  // Wait after the low nibble of a byte
  function automatic logic [WAIT_W-1:0] byte_post(input logic rs, input extra_e extra);
    logic [WAIT_W-1:0] settle;
    logic [WAIT_W-1:0] add;
    settle = rs ? DATA_SETTLE_US : CMD_SETTLE_US;
    case (extra)
      EXTRA_CURSOR: add = CURSOR_EXTRA_US;
      EXTRA_CLEAR:  add = CLEAR_EXTRA_US;
      default:      add = '0;
    endcase
    return NIB_POST_US + settle + add;
  endfunction

  // One nibble transfer of a byte
  function automatic xfer_t byte_xfer(input logic rs, input logic [7:0] b,
                                      input logic low, input extra_e extra,
                                      input logic last);
    xfer_t x;
    x.reg_select   = rs;
    x.nibble       = low ? b[3:0] : b[7:4];
    x.pre_wait_us  = low ? '0 : RS_SETUP_US;
    x.post_wait_us = low ? byte_post(rs, extra) : NIB_POST_US;
    x.last         = last;
    return x;
  endfunction

  // Power-up sequence, one entry per transfer
  function automatic xfer_t init_xfer(input logic [STEP_W-1:0] step);
    xfer_t      x;
    logic [7:0] b;
    logic       fin;
    fin = (step == STEP_W'(INIT_XFERS - 1));
    unique case (step[STEP_W-1:1])
      3'd2:    b = CMD_FUNC_SET;
      3'd3:    b = CMD_DISP_ON;
      3'd4:    b = CMD_ENTRY;
      default: b = CMD_CLEAR;
    endcase
    if (step < STEP_W'(4)) begin
      x.reg_select   = 1'b0;
      x.nibble       = (step == STEP_W'(3)) ? NIB_4BIT : NIB_WAKE;
      x.pre_wait_us  = (step == '0) ? POWER_UP_US : '0;
      x.post_wait_us = (step == '0) ? WAKE_FIRST_US : WAKE_NEXT_US;
      x.last         = 1'b0;
    end else begin
      x = byte_xfer(1'b0, b, step[0], fin ? EXTRA_CLEAR : EXTRA_NONE, fin);
    end
    return x;
  endfunction

endpackage

/* rtl/core/clcd4_req_if.sv */
// Request channel of the character LCD controller: valid/ready plus request fields.
// Depends on nothing.
interface clcd4_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] byte_value;
  logic [5:0] target_col;
  logic       target_row;
  logic [2:0] glyph_slot;

  modport source (output valid, func, byte_value, target_col, target_row, glyph_slot,
                  input ready);
  modport sink   (input valid, func, byte_value, target_col, target_row, glyph_slot,
                  output ready);
endinterface

/* rtl/core/clcd4_xfer_if.sv */
// Transfer channel of the character LCD controller: valid/ready plus nibble fields.
// Depends on nothing.
interface clcd4_xfer_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [14:0] pre_wait_us;
  logic [14:0] post_wait_us;
  logic        last;

  modport source (output valid, reg_select, nibble, pre_wait_us, post_wait_us, last,
                  input ready);
  modport sink   (input valid, reg_select, nibble, pre_wait_us, post_wait_us, last,
                  output ready);
endinterface

/* rtl/core/clcd4_front.sv */
// Front end: accepts requests, tracks the cursor, and turns each request into a job.
// Depends on clcd4_pkg and clcd4_req_if.
module clcd4_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [clcd4_pkg::COL_W-1:0]  cfg_wdata_i,
  clcd4_req_if.sink                    req_i,
  input  logic                         full_i,
  output logic                         push_o,
  output clcd4_pkg::job_t              job_o
);

  logic [clcd4_pkg::COL_W-1:0] line_length_q;
  logic [clcd4_pkg::COL_W-1:0] col_q, col_d;
  logic                        row_q, row_d;
  logic                        wrap;
  logic [7:0]                  addr_sum;
  clcd4_pkg::job_t             job_d;

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;
  assign job_o       = job_d;

  assign wrap     = (col_q >= line_length_q);
  assign addr_sum = {1'b0, req_i.target_row, 6'b0} + {2'b00, req_i.target_col};

  // Classify the request and work out the cursor that follows it
  always_comb begin
    job_d           = '0;
    job_d.extra     = clcd4_pkg::EXTRA_NONE;
    job_d.main_byte = req_i.byte_value;
    row_d           = row_q;
    col_d           = col_q;
    unique case (clcd4_pkg::func_e'(req_i.func))
      clcd4_pkg::FUNC_INIT: begin
        job_d.is_init = 1'b1;
        row_d         = 1'b0;
        col_d         = '0;
      end
      clcd4_pkg::FUNC_CMD: begin
        job_d.rs = 1'b0;
      end
      clcd4_pkg::FUNC_DATA: begin
        job_d.rs = 1'b1;
      end
      clcd4_pkg::FUNC_CHAR: begin
        job_d.rs = 1'b1;
        if (wrap) begin
          job_d.has_pre  = 1'b1;
          job_d.pre_byte = clcd4_pkg::CMD_DDRAM | (row_q ? 8'h00 : clcd4_pkg::ROW1_OFFSET);
          row_d          = !row_q;
          col_d          = clcd4_pkg::COL_W'(1);
        end else begin
          col_d = col_q + clcd4_pkg::COL_W'(1);
        end
      end
      clcd4_pkg::FUNC_CURSOR: begin
        job_d.main_byte = clcd4_pkg::CMD_DDRAM | addr_sum;
        job_d.extra     = clcd4_pkg::EXTRA_CURSOR;
        row_d           = req_i.target_row;
        col_d           = req_i.target_col;
      end
      clcd4_pkg::FUNC_CLEAR: begin
        job_d.main_byte = clcd4_pkg::CMD_CLEAR;
        job_d.extra     = clcd4_pkg::EXTRA_CLEAR;
        row_d           = 1'b0;
        col_d           = '0;
      end
      clcd4_pkg::FUNC_HOME: begin
        job_d.main_byte = clcd4_pkg::CMD_HOME;
        job_d.extra     = clcd4_pkg::EXTRA_CLEAR;
        row_d           = 1'b0;
        col_d           = '0;
      end
      clcd4_pkg::FUNC_GLYPH: begin
        job_d.main_byte = {2'b01, req_i.glyph_slot, 3'b000};
      end
    endcase
  end

  // Hold the line length and the cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= clcd4_pkg::LINE_LENGTH_RST;
      row_q         <= 1'b0;
      col_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        line_length_q <= cfg_wdata_i;
      end
      if (push_o) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

endmodule

/* rtl/core/clcd4_fifo.sv */
// Job queue between the front end and the transfer sequencer.
// Depends on clcd4_pkg and assert_macros.svh.
`include "assert_macros.svh"
module clcd4_fifo #(
  parameter int unsigned Depth = clcd4_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  clcd4_pkg::job_t job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output clcd4_pkg::job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  clcd4_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `CLCD4_ASSERT(a_count_bound, count_q <= CntW'(Depth))
  `CLCD4_ASSERT(a_no_pop_empty, pop_i |-> count_q != '0)
  `CLCD4_ASSERT(a_no_push_full, push_i |-> !full_o)

endmodule

/* rtl/core/clcd4_back.sv */
// Transfer sequencer: walks the head job nibble by nibble into a registered output.
// Depends on clcd4_pkg, clcd4_xfer_if and assert_macros.svh.
`include "assert_macros.svh"
module clcd4_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  clcd4_pkg::job_t job_i,
  output logic            pop_o,
  clcd4_xfer_if.source    xfer_o
);

  logic [clcd4_pkg::STEP_W-1:0] step_q;
  logic [clcd4_pkg::STEP_W-1:0] total;
  logic                         load;
  logic                         on_pre;
  clcd4_pkg::xfer_t             gen;
  clcd4_pkg::xfer_t             out_q;
  logic                         out_valid_q;

  assign load  = valid_i && (!out_valid_q || xfer_o.ready);
  assign pop_o = load && gen.last;

  assign total  = job_i.is_init ? clcd4_pkg::STEP_W'(clcd4_pkg::INIT_XFERS)
                : (job_i.has_pre ? clcd4_pkg::STEP_W'(4) : clcd4_pkg::STEP_W'(2));
  assign on_pre = job_i.has_pre && !step_q[1];

  // Build the transfer for the current step
  always_comb begin
    if (job_i.is_init) begin
      gen = clcd4_pkg::init_xfer(step_q);
    end else if (on_pre) begin
      gen = clcd4_pkg::byte_xfer(1'b0, job_i.pre_byte, step_q[0],
                                 clcd4_pkg::EXTRA_CURSOR, 1'b0);
    end else begin
      gen = clcd4_pkg::byte_xfer(job_i.rs, job_i.main_byte, step_q[0], job_i.extra,
                                 step_q == total - clcd4_pkg::STEP_W'(1));
    end
  end

  // Advance the step; drop back to zero when the job is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q <= gen.last ? '0 : step_q + clcd4_pkg::STEP_W'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (xfer_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= gen;
    end
  end

  assign xfer_o.valid        = out_valid_q;
  assign xfer_o.reg_select   = out_q.reg_select;
  assign xfer_o.nibble       = out_q.nibble;
  assign xfer_o.pre_wait_us  = out_q.pre_wait_us;
  assign xfer_o.post_wait_us = out_q.post_wait_us;
  assign xfer_o.last         = out_q.last;

  `CLCD4_ASSERT(a_step_in_job, valid_i |-> step_q < total)
  `CLCD4_ASSERT(a_pop_last, pop_o |=> out_valid_q && xfer_o.last)
  `CLCD4_ASSERT(a_idle_step, !valid_i |-> step_q == '0)

endmodule

/* rtl/core/char_lcd_4bit_interface_top.sv */
// Top level of the 4-bit character LCD controller: front end, job queue, sequencer.
// Depends on clcd4_pkg, clcd4_req_if, clcd4_xfer_if, clcd4_front, clcd4_fifo, clcd4_back.
//
// Each request on req_i becomes a run of nibble transfers on xfer_o, each with
// its RS level, nibble and the microsecond waits around its enable pulse;
// last marks the final transfer of a request. The front end takes one request
// per cycle while the job queue (QueueDepth entries) has room, and tracks the
// cursor so that character writes wrap to the other row. The sequencer emits
// one transfer per cycle into a registered output while xfer_o is ready, so a
// request takes 2 transfers, 4 for a character write that wraps, and 12 for
// init; the sustained rate is set by that sequencer. line_length is written
// through cfg_we_i and cfg_wdata_i and resets to 16. No clearing pass runs after reset.
module char_lcd_4bit_interface_top #(
  parameter int unsigned QueueDepth = clcd4_pkg::QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [clcd4_pkg::COL_W-1:0] cfg_wdata_i,
  clcd4_req_if.sink                   req_i,
  clcd4_xfer_if.source                xfer_o
);

  logic            push, full, pop, job_valid;
  clcd4_pkg::job_t push_job, head_job;

  // Accept and classify requests
  clcd4_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Decouple front end and sequencer
  clcd4_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (head_job)
  );

  // Emit transfers
  clcd4_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (job_valid),
    .job_i   (head_job),
    .pop_o   (pop),
    .xfer_o  (xfer_o)
  );

endmodule
